### design/hsfe_pkg.sv
`timescale 1ns / 1ps

package hsfe_pkg;

    localparam logic [1:0] K_DATA  = 2'd0;
    localparam logic [1:0] K_END   = 2'd1;
    localparam logic [1:0] K_ABORT = 2'd2;
    localparam logic [1:0] K_IDLE  = 2'd3;

    localparam logic [7:0] B_ESC    = 8'h7D;
    localparam logic [7:0] B_FLAG   = 8'h7E;
    localparam logic [7:0] B_ABORT  = 8'h7F;
    localparam logic [7:0] ESC_FLIP = 8'h20;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [7:0]  SCR_SEED = 8'h01;
    localparam logic [7:0]  SCR_TAPS = 8'hB8;

    // A queue entry holds up to three unescaped bytes.
    localparam int ENTRY_BYTES = 3;
    localparam int IDX_W       = 2;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [ENTRY_BYTES-1:0][7:0] bytes;
        logic [ENTRY_BYTES-1:0]      esc_en;
        logic [IDX_W-1:0]            last_idx;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    typedef struct packed {
        logic   empty;
        logic   full;
        entry_t head;
    } fifo_stat_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = crc[7:0] ^ b;
        t = t ^ {t[3:0], 4'b0000};
        crc_update = {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
                     ^ {12'h000, t[7:4]};
    endfunction

    function automatic logic [7:0] scr_next(input logic [7:0] s);
        scr_next = s[0] ? ({1'b0, s[7:1]} ^ SCR_TAPS) : {1'b0, s[7:1]};
    endfunction

endpackage

### design/hsfe_fifo.sv
`timescale 1ns / 1ps

module hsfe_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsfe_pkg::push_t      wr,
    input  logic                 pop,
    output hsfe_pkg::fifo_stat_t stat
);
    import hsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem[wr_ptr_reg] <= wr.entry;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr.push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr.push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.head  = mem[rd_ptr_reg];

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.push && count_reg == FULL_CNT && !pop))
        else $error("queue pushed while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

### design/hsfe_front.sv
`timescale 1ns / 1ps

module hsfe_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      kind,
    input  logic [7:0]      data_byte,
    input  logic            q_full,
    output hsfe_pkg::push_t wr
);
    import hsfe_pkg::*;

    // Only whether the last byte sent was a flag or an abort matters later on.
    typedef enum logic [1:0] {LS_OTHER, LS_FLAG, LS_ABORT} last_t;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  scr_reg;
    logic [7:0]  scr_next_v;
    logic        active_reg;
    logic        active_next;
    last_t       last_reg;
    last_t       last_next;
    logic        accept;
    entry_t      entry;
    logic        push;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        crc_next    = crc_reg;
        scr_next_v  = scr_reg;
        active_next = active_reg;
        last_next   = last_reg;
        push        = 1'b0;
        entry       = '0;
        unique case (kind)
            K_DATA:
            begin
                crc_next       = crc_update(crc_reg, data_byte);
                scr_next_v     = scr_next(scr_reg);
                active_next    = 1'b1;
                // The final byte of a data item is never a bare flag or abort.
                last_next      = LS_OTHER;
                push           = 1'b1;
                entry.bytes[0] = data_byte ^ scr_next_v;
                entry.esc_en   = 3'b001;
                entry.last_idx = IDX_W'(0);
            end
            K_END:
            begin
                crc_next       = CRC_INIT;
                scr_next_v     = SCR_SEED;
                active_next    = 1'b1;
                last_next      = LS_FLAG;
                push           = 1'b1;
                entry.bytes[0] = crc_reg[15:8];
                entry.bytes[1] = crc_reg[7:0];
                entry.bytes[2] = B_FLAG;
                entry.esc_en   = 3'b011;
                entry.last_idx = IDX_W'(2);
            end
            K_ABORT:
            begin
                crc_next       = CRC_INIT;
                scr_next_v     = SCR_SEED;
                active_next    = 1'b1;
                last_next      = LS_ABORT;
                push           = 1'b1;
                entry.bytes[0] = B_ABORT;
                entry.esc_en   = 3'b000;
                entry.last_idx = IDX_W'(0);
            end
            default:
            begin
                push           = active_reg && (last_reg != LS_OTHER);
                entry.bytes[0] = (last_reg == LS_ABORT) ? B_ABORT : B_FLAG;
                entry.esc_en   = 3'b000;
                entry.last_idx = IDX_W'(0);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= CRC_INIT;
            scr_reg    <= SCR_SEED;
            active_reg <= 1'b0;
            last_reg   <= LS_OTHER;
        end
        else if (accept)
        begin
            crc_reg    <= crc_next;
            scr_reg    <= scr_next_v;
            active_reg <= active_next;
            last_reg   <= last_next;
        end
    end

    assign wr.push  = accept && push;
    assign wr.entry = entry;

endmodule

### design/hsfe_back.sv
`timescale 1ns / 1ps

module hsfe_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsfe_pkg::fifo_stat_t stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 last
);
    import hsfe_pkg::*;

    logic [IDX_W-1:0] pos_reg;
    logic             esc_phase_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic             advance;
    logic             emit;
    logic [7:0]       cur;
    logic             need_esc;
    logic             final_byte;

    assign advance    = !out_valid_reg || out_ready;
    assign emit       = advance && !stat.empty;
    assign cur        = stat.head.bytes[pos_reg];
    assign need_esc   = stat.head.esc_en[pos_reg]
                        && (cur == B_ESC || cur == B_FLAG || cur == B_ABORT);
    assign final_byte = (pos_reg == stat.head.last_idx);
    // The escape byte goes out first; the entry stays until its last byte leaves.
    assign pop        = emit && final_byte && !(need_esc && !esc_phase_reg);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (need_esc && !esc_phase_reg)
            begin
                out_byte_reg <= B_ESC;
                out_last_reg <= 1'b0;
            end
            else
            begin
                out_byte_reg <= esc_phase_reg ? (cur ^ ESC_FLIP) : cur;
                out_last_reg <= final_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            esc_phase_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
            if (emit)
            begin
                if (need_esc && !esc_phase_reg)
                begin
                    esc_phase_reg <= 1'b1;
                end
                else
                begin
                    esc_phase_reg <= 1'b0;
                    pos_reg       <= final_byte ? '0 : pos_reg + IDX_W'(1);
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = out_last_reg;

    a_esc_shown: assert property (@(posedge clk) disable iff (!rst_n)
        esc_phase_reg |-> (out_valid_reg && out_byte_reg == B_ESC && !out_last_reg))
        else $error("escape pending without escape byte on output");

    a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_byte_reg == B_ESC) |-> !out_last_reg)
        else $error("escape byte marked as final byte");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < IDX_W'(ENTRY_BYTES))
        else $error("byte position out of range");

endmodule

### design/hdlc_scrambled_frame_encoder_top.sv
`timescale 1ns / 1ps

// Async-HDLC transmit framer, scrambled payload, CRC-16 (X.25 poly and preset,
// no final XOR). A front end takes one input transaction per cycle unless the
// queue is full, updates the CRC and scrambler, writes the item's unescaped
// bytes into a small queue (FIFO_DEPTH entries); idle ticks that send nothing
// are taken and dropped. The back end reads the queue, inserts escapes and,
// unless out_ready stalls it, drives one output byte per cycle through its
// output register. Bytes per item: data 1-2, frame end 3-5, abort or repeat 1.
module hdlc_scrambled_frame_encoder_top #(
    parameter int FIFO_DEPTH = hsfe_pkg::FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last
);
    import hsfe_pkg::*;

    push_t      wr;
    fifo_stat_t stat;
    logic       pop;

    hsfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .q_full    (stat.full),
        .wr        (wr)
    );

    hsfe_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .stat  (stat)
    );

    hsfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import hsfe_pkg::*;

    localparam logic [15:0] CRC_POLY_REV = 16'h8408;
    localparam int PLANNED_ITEMS = 165;
    localparam int CALM_TAIL = 25;
    localparam int HOLD_AT_ITEM = 30;
    localparam int HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] SPECIAL_BYTES [3] = '{B_ESC, B_FLAG, B_ABORT};

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } line_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind = K_IDLE;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last;

    frame_item_t frame_items_q[$];
    line_byte_t  line_bytes_q[$];

    // Encoder state as the block should hold it.
    logic [15:0] enc_crc = CRC_INIT;
    logic [7:0]  enc_scr = SCR_SEED;
    logic [7:0]  enc_last_sent = 8'h00;
    logic        enc_active = 1'b0;

    // Shadow state used while building the stimulus, so that data bytes can
    // be picked to land on escape codes.
    logic [15:0] plan_crc = CRC_INIT;
    logic [7:0]  plan_scr = SCR_SEED;
    int          n_planned = 0;

    logic took_item = 1'b0;
    logic calm = 1'b0;
    int   send_gap = 0;
    int   take_gap = 0;
    int   hold_left = 0;
    logic held_once = 1'b0;
    int   stall_cycles = 0;

    int n_items = 0;
    int n_bytes = 0;
    int n_escapes = 0;
    int n_ends = 0;
    int n_aborts = 0;
    int n_repeats = 0;
    int errors = 0;

    hdlc_scrambled_frame_encoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REV) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] scr_step(input logic [7:0] s);
        return (s >> 1) ^ (s[0] ? SCR_TAPS : 8'h00);
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        return (b == B_ESC) || (b == B_FLAG) || (b == B_ABORT);
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Works out the line bytes of one accepted transaction and queues them.
    task automatic encode_item(input logic [1:0] k, input logic [7:0] d);
        logic [7:0] plain[$];
        logic [7:0] line[$];
        logic [7:0] tail;
        logic       has_tail;
        line_byte_t lb;
        has_tail = 1'b0;
        tail = 8'h00;
        case (k)
            K_DATA:
            begin
                enc_active = 1'b1;
                enc_crc = crc_step(enc_crc, d);
                enc_scr = scr_step(enc_scr);
                plain.push_back(d ^ enc_scr);
            end
            K_END:
            begin
                enc_active = 1'b1;
                plain.push_back(enc_crc[15:8]);
                plain.push_back(enc_crc[7:0]);
                tail = B_FLAG;
                has_tail = 1'b1;
                enc_crc = CRC_INIT;
                enc_scr = SCR_SEED;
            end
            K_ABORT:
            begin
                enc_active = 1'b1;
                tail = B_ABORT;
                has_tail = 1'b1;
                enc_crc = CRC_INIT;
                enc_scr = SCR_SEED;
            end
            default:
            begin
                if (enc_active && (enc_last_sent == B_FLAG || enc_last_sent == B_ABORT))
                begin
                    tail = enc_last_sent;
                    has_tail = 1'b1;
                end
            end
        endcase
        foreach (plain[i])
        begin
            if (is_special(plain[i]))
            begin
                line.push_back(B_ESC);
                line.push_back(plain[i] ^ ESC_FLIP);
            end
            else
            begin
                line.push_back(plain[i]);
            end
        end
        if (has_tail)
        begin
            line.push_back(tail);
        end
        foreach (line[i])
        begin
            lb.value = line[i];
            lb.last = (i == line.size() - 1);
            line_bytes_q.push_back(lb);
        end
        if (line.size() > 0)
        begin
            enc_last_sent = line[line.size() - 1];
        end
    endtask

    task automatic plan_item(input logic [1:0] k, input logic [7:0] d);
        frame_item_t it;
        it.kind = k;
        it.data = d;
        frame_items_q.push_back(it);
        n_planned++;
        case (k)
            K_DATA:
            begin
                plan_crc = crc_step(plan_crc, d);
                plan_scr = scr_step(plan_scr);
            end
            K_END, K_ABORT:
            begin
                plan_crc = CRC_INIT;
                plan_scr = SCR_SEED;
            end
            default:
            begin
            end
        endcase
    endtask

    // A data byte whose scrambled form equals the given line code.
    task automatic plan_data_onto(input logic [7:0] target);
        plan_item(K_DATA, target ^ scr_step(plan_scr));
    endtask

    // Two data bytes chosen so that the CRC high byte (want[0]), the low byte
    // (want[1]) or both need escaping at the end of the frame.
    task automatic plan_crc_tail(input logic [1:0] want);
        logic [15:0] c;
        logic        found;
        int unsigned pick;
        found = 1'b0;
        pick = 0;
        for (int unsigned i = 0; i < 65536 && !found; i++)
        begin
            c = crc_step(crc_step(plan_crc, 8'(i >> 8)), 8'(i));
            if ((!want[0] || is_special(c[15:8])) && (!want[1] || is_special(c[7:0])))
            begin
                found = 1'b1;
                pick = i;
            end
        end
        if (!found)
        begin
            pick = $urandom_range(0, 65535);
        end
        plan_item(K_DATA, 8'(pick >> 8));
        plan_item(K_DATA, 8'(pick));
    endtask

    // Input side: presents one transaction at a time, with short idle bursts.
    always @(negedge clk)
    begin : drive_items
        frame_item_t it;
        calm <= (frame_items_q.size() < CALM_TAIL);
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || took_item)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 2);
                in_valid <= 1'b0;
            end
            else if (frame_items_q.size() > 0)
            begin
                it = frame_items_q.pop_front();
                in_valid <= 1'b1;
                kind <= it.kind;
                data_byte <= it.data;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: random short stalls, plus one long hold-off early on that
    // backs the block up until it stops taking input.
    always @(negedge clk)
    begin : drive_ready
        if (!held_once && n_items >= HOLD_AT_ITEM)
        begin
            hold_left = HOLD_CYCLES;
            held_once = 1'b1;
        end
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (take_gap > 0)
        begin
            take_gap = take_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            take_gap = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watch_ports
        line_byte_t want;
        if (rst_n)
        begin
            took_item <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                n_items++;
                if (kind == K_END)
                begin
                    n_ends++;
                end
                if (kind == K_ABORT)
                begin
                    n_aborts++;
                end
                encode_item(kind, data_byte);
            end
            if (out_valid && out_ready)
            begin
                n_bytes++;
                if (line_bytes_q.size() == 0)
                begin
                    report_mismatch($sformatf("byte %h with nothing expected", out_byte));
                end
                else
                begin
                    want = line_bytes_q.pop_front();
                    if (want.value == B_ESC)
                    begin
                        n_escapes++;
                    end
                    if (out_byte !== want.value)
                    begin
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  out_byte, want.value));
                    end
                    if (last !== want.last)
                    begin
                        report_mismatch($sformatf("last %b, expected %b on byte %h",
                                                  last, want.last, want.value));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int nd;
        int r;
        // Directed part.
        plan_item(K_IDLE, 8'hA5);       // idle before any frame: nothing sent
        plan_item(K_ABORT, 8'h00);
        plan_item(K_IDLE, 8'hFF);       // repeats the abort
        plan_item(K_END, 8'hFF);        // empty frame
        plan_item(K_IDLE, 8'h00);       // repeats the flag
        plan_item(K_DATA, 8'h00);
        plan_item(K_DATA, 8'hFF);
        plan_data_onto(B_ESC);
        plan_data_onto(B_FLAG);
        plan_data_onto(B_ABORT);
        plan_item(K_IDLE, 8'h5A);       // after a data byte: nothing sent
        plan_item(K_END, 8'h00);
        plan_crc_tail(2'b01);
        plan_item(K_END, 8'h81);
        plan_crc_tail(2'b10);
        plan_item(K_END, 8'h18);
        plan_crc_tail(2'b11);
        plan_item(K_END, 8'hE7);
        plan_item(K_DATA, 8'h3C);
        plan_item(K_DATA, 8'hC3);
        plan_item(K_ABORT, 8'hFF);      // abort drops the partial frame
        plan_item(K_DATA, 8'h55);
        plan_item(K_END, 8'hAA);

        // Random frames, mostly well formed, with idles and aborts mixed in.
        while (n_planned < PLANNED_ITEMS)
        begin
            nd = $urandom_range(0, 6);
            for (int j = 0; j < nd; j++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    plan_data_onto(SPECIAL_BYTES[$urandom_range(0, 2)]);
                end
                else if (r == 1)
                begin
                    plan_item(K_IDLE, 8'($urandom));
                end
                else
                begin
                    plan_item(K_DATA, 8'($urandom));
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                plan_crc_tail(2'($urandom_range(1, 3)));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                plan_item(K_ABORT, 8'($urandom));
            end
            else
            begin
                plan_item(K_END, 8'($urandom));
            end
            repeat ($urandom_range(0, 2))
            begin
                plan_item(K_IDLE, 8'($urandom));
            end
        end

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        while (frame_items_q.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (line_bytes_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transactions: %0d frames closed, %0d aborts.",
                 n_items, n_ends, n_aborts);
        $display("Checked %0d line bytes, %0d of them escape marks.", n_bytes, n_escapes);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
